/* hdl/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller package
// Default sizes, the multiplier digit width and the configuration register
// indexes and the product selector codes of the PID controller step.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  // Default data word and fraction sizes (Q16.16 in 32 bits).
  localparam int unsigned DEF_DATA_WIDTH = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  // Bits of the multiplier operand consumed per multiplier cycle.
  localparam int unsigned MUL_DIGIT = 16;

  // Configuration port register index.
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd4;

  // Product selector of the shared multiplier.
  localparam logic [1:0] OP_ERR_DT = 2'd0;
  localparam logic [1:0] OP_KP     = 2'd1;
  localparam logic [1:0] OP_KI     = 2'd2;
  localparam logic [1:0] OP_KD     = 2'd3;

endpackage : pidc_pkg

`default_nettype wire

/* hdl/pid_controller_step.sv */
// Operands are multiplied in NDIG = ceil(DATA_WIDTH/16) digits and the divider
// forms NUMW = DATA_WIDTH+FRAC_BITS+2 quotient bits (50 at Q16.16); the divider
// and the derivative product are skipped when time_step is zero.
// Throughput: a new word is accepted only in idle, once the previous word has
// passed the bit-serial divider and up to four passes through the shared multiplier.
// Reset: gains clear, the clamp range opens fully, stored error and integral clear.
// ----------------------------------------------------------------------------
// PID controller step
// Fixed-point PID step with a shared digit-serial multiplier, a restoring
// divider for the derivative and one shared clamp unit under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_step
  import pidc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] feedback_i,
  input  wire logic signed [DATA_WIDTH-1:0] setpoint_i,
  input  wire logic        [DATA_WIDTH-1:0] time_step_i,
  input  wire logic                         restart_i,
  // Output channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed      [DATA_WIDTH-1:0] drive_o,
  output logic                              zero_step_o,
  // Configuration port
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [DATA_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned SATW = W + 8;                 // saturated term width
  localparam int unsigned AW   = W + 8;                 // multiplicand magnitude
  localparam int unsigned NDIG = (W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned BPW  = NDIG * MUL_DIGIT;      // padded multiplier
  localparam int unsigned PW   = AW + BPW;              // product width
  localparam int unsigned EW   = PW + SATW;             // scaled product width
  localparam int unsigned NUMW = W + 2 + FRAC_BITS;     // dividend width
  localparam int unsigned ACCW = SATW + 2;              // term sum width
  localparam int unsigned CW   = $clog2(NUMW);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_SCALE  = 4'd3;
  localparam logic [3:0] ST_ACC    = 4'd4;
  localparam logic [3:0] ST_CLAMPI = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_DSAT   = 4'd7;
  localparam logic [3:0] ST_DRIVE  = 4'd8;

  // Control and state registers
  logic [3:0]               state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [W:0]        prev_q, prev_d;
  logic signed [W-1:0]      integ_q, integ_d;
  logic signed [W-1:0]      kp_q, ki_q, kd_q, min_q, max_q;

  // Datapath registers
  logic signed [W:0]        err_q, err_d;
  logic signed [W+1:0]      diff_q, diff_d;
  logic [W-1:0]             dt_q, dt_d;
  logic [AW-1:0]            mula_q, mula_d;
  logic [BPW-1:0]           mulb_q, mulb_d;
  logic                     neg_q, neg_d;
  logic [PW-1:0]            prod_q, prod_d;
  logic signed [SATW-1:0]   term_q, term_d;
  logic signed [ACCW-1:0]   acc_q, acc_d;
  logic [NUMW-1:0]          dq_q, dq_d;
  logic [W-1:0]             rem_q, rem_d;
  logic signed [W-1:0]      drive_q, drive_d;
  logic                     zero_q, zero_d;

  // Magnitudes of the signed operands.
  logic [W:0]               err_mag;
  logic [W+1:0]             diff_mag;
  logic [W-1:0]             integ_mag, kp_mag, ki_mag, kd_mag;

  assign err_mag   = err_q[W]    ? $unsigned(-err_q)   : $unsigned(err_q);
  assign diff_mag  = diff_q[W+1] ? $unsigned(-diff_q)  : $unsigned(diff_q);
  assign integ_mag = integ_q[W-1] ? $unsigned(-integ_q) : $unsigned(integ_q);
  assign kp_mag    = kp_q[W-1]   ? $unsigned(-kp_q)    : $unsigned(kp_q);
  assign ki_mag    = ki_q[W-1]   ? $unsigned(-ki_q)    : $unsigned(ki_q);
  assign kd_mag    = kd_q[W-1]   ? $unsigned(-kd_q)    : $unsigned(kd_q);

  // One multiplier digit: multiplicand times the top digit of the multiplier.
  logic [AW+MUL_DIGIT-1:0]  mul_pp;
  assign mul_pp = mula_q * mulb_q[BPW-1 -: MUL_DIGIT];

  // Drop the fraction bits of the product and saturate symmetrically.
  logic [EW-1:0]            prod_ext;
  logic [SATW-2:0]          prod_sat;
  logic signed [SATW-1:0]   prod_pos;
  assign prod_ext = {{SATW{1'b0}}, prod_q} >> FRAC_BITS;
  assign prod_sat = (|prod_ext[EW-1:SATW-1]) ? {(SATW-1){1'b1}} : prod_ext[SATW-2:0];
  assign prod_pos = $signed({1'b0, prod_sat});

  // Saturated magnitude of the derivative quotient.
  logic [SATW-2:0]          quo_sat;
  assign quo_sat = (|dq_q[NUMW-1:SATW-1]) ? {(SATW-1){1'b1}} : dq_q[SATW-2:0];

  // One restoring divider step.
  logic [W:0]               div_try, div_sub;
  logic                     div_ge;
  assign div_try = {rem_q, dq_q[NUMW-1]};
  assign div_sub = div_try - {1'b0, dt_q};
  assign div_ge  = (div_try >= {1'b0, dt_q});

  // Shared clamp: raise to out_min first, then lower to out_max.
  logic                     clamp_lt, clamp_gt, clamp_inv;
  logic signed [W-1:0]      clamp_res;
  assign clamp_lt  = (acc_q < ACCW'(min_q));
  assign clamp_gt  = (acc_q > ACCW'(max_q));
  assign clamp_inv = (min_q > max_q);
  always_comb begin
    if (clamp_lt) begin
      clamp_res = clamp_inv ? max_q : min_q;
    end else if (clamp_gt) begin
      clamp_res = max_q;
    end else begin
      clamp_res = acc_q[W-1:0];
    end
  end

  // Operand selection when a product starts.
  logic                     mul_start;
  logic [1:0]               mul_op;
  logic [AW-1:0]            sel_a;
  logic [W-1:0]             sel_b;
  logic                     sel_neg;
  always_comb begin
    unique case (mul_op)
      OP_ERR_DT: begin
        sel_a   = AW'(err_mag);
        sel_b   = dt_q;
        sel_neg = err_q[W];
      end
      OP_KP: begin
        sel_a   = AW'(err_mag);
        sel_b   = kp_mag;
        sel_neg = err_q[W] ^ kp_q[W-1];
      end
      OP_KI: begin
        sel_a   = AW'(integ_mag);
        sel_b   = ki_mag;
        sel_neg = integ_q[W-1] ^ ki_q[W-1];
      end
      default: begin
        sel_a   = AW'(quo_sat);
        sel_b   = kd_mag;
        sel_neg = diff_q[W+1] ^ kd_q[W-1];
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    err_d       = err_q;
    diff_d      = diff_q;
    dt_d        = dt_q;
    mula_d      = mula_q;
    mulb_d      = mulb_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    term_d      = term_q;
    acc_d       = acc_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    drive_d     = drive_q;
    zero_d      = zero_q;
    mul_start   = 1'b0;
    mul_op      = OP_ERR_DT;

    // The waiting result word leaves when taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d = (W+1)'(setpoint_i) - (W+1)'(feedback_i);
          dt_d  = time_step_i;
          if (restart_i) begin
            prev_d  = '0;
            integ_d = '0;
          end
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        diff_d    = (W+2)'(err_q) - (W+2)'(prev_q);
        mul_start = 1'b1;
        mul_op    = OP_ERR_DT;
      end
      ST_MUL: begin
        prod_d = (prod_q << MUL_DIGIT) + PW'(mul_pp);
        mulb_d = mulb_q << MUL_DIGIT;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        term_d  = neg_q ? -prod_pos : prod_pos;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        unique case (op_q)
          OP_ERR_DT: begin
            acc_d   = ACCW'(integ_q) + ACCW'(term_q);
            state_d = ST_CLAMPI;
          end
          OP_KP: begin
            acc_d     = ACCW'(term_q);
            mul_start = 1'b1;
            mul_op    = OP_KI;
          end
          OP_KI: begin
            acc_d = acc_q + ACCW'(term_q);
            if (dt_q == '0) begin
              state_d = ST_DRIVE;
            end else begin
              dq_d    = {diff_mag, {FRAC_BITS{1'b0}}};
              rem_d   = '0;
              cnt_d   = CW'(NUMW - 1);
              state_d = ST_DIV;
            end
          end
          default: begin
            acc_d   = acc_q + ACCW'(term_q);
            state_d = ST_DRIVE;
          end
        endcase
      end
      ST_CLAMPI: begin
        integ_d   = clamp_res;
        mul_start = 1'b1;
        mul_op    = OP_KP;
      end
      ST_DIV: begin
        rem_d = div_ge ? div_sub[W-1:0] : div_try[W-1:0];
        dq_d  = {dq_q[NUMW-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DSAT;
        end
      end
      ST_DSAT: begin
        mul_start = 1'b1;
        mul_op    = OP_KD;
      end
      ST_DRIVE: begin
        // Hold here while the previous result word still waits.
        if (!out_valid_q || out_ready_i) begin
          drive_d     = clamp_res;
          zero_d      = (dt_q == '0);
          out_valid_d = 1'b1;
          prev_d      = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load the shared multiplier.
    if (mul_start) begin
      op_d    = mul_op;
      mula_d  = sel_a;
      mulb_d  = BPW'(sel_b);
      neg_d   = sel_neg;
      prod_d  = '0;
      cnt_d   = CW'(NDIG - 1);
      state_d = ST_MUL;
    end
  end

  // Control state, stored error and integral, and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ERR_DT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      integ_q     <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      min_q       <= {1'b1, {(W-1){1'b0}}};
      max_q       <= {1'b0, {(W-1){1'b1}}};
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KP_GAIN: kp_q  <= $signed(cfg_data_i);
          REG_KI_GAIN: ki_q  <= $signed(cfg_data_i);
          REG_KD_GAIN: kd_q  <= $signed(cfg_data_i);
          REG_OUT_MIN: min_q <= $signed(cfg_data_i);
          REG_OUT_MAX: max_q <= $signed(cfg_data_i);
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    diff_q  <= diff_d;
    dt_q    <= dt_d;
    mula_q  <= mula_d;
    mulb_q  <= mulb_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    term_q  <= term_d;
    acc_q   <= acc_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    drive_q <= drive_d;
    zero_q  <= zero_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign zero_step_o = zero_q;

  // An accepted word always starts the sequence.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_PREP)
    else $error("accepted word did not start the sequence");

  // A new result word only comes out of the final clamp step.
  a_result_from_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DRIVE)
    else $error("result word appeared outside the final clamp step");

  // The divider never runs on a zero time step.
  a_no_div_by_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> dt_q != '0)
    else $error("divider started with a zero time step");

  // The multiplier digit count stays within the operand.
  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> cnt_q < CW'(NDIG))
    else $error("multiplier digit count out of range");

endmodule : pid_controller_step

`default_nettype wire
